@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, switched off while reset is low.
`define IFP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define IFP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ design/ifp_pkg.sv @@
package ifp_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int BYTE_W      = 8;
  localparam int RAW_W       = 16;
  localparam int GAIN_W      = 21;
  localparam int AXIS_W      = 20;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int FILL_W      = $clog2(FRAME_BYTES);
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = RAW_W + GAIN_W;

  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_MASK   = 8'h50;
  localparam logic [BYTE_W-1:0] KIND_FIRST = 8'h51;
  localparam logic [BYTE_W-1:0] KIND_LAST  = 8'h54;

  localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 21'd314;
  localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 21'd4000;
  localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 21'd360;
  localparam logic [GAIN_W-1:0] MAG_GAIN_RST   = 21'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_GAIN = 2'd0,
    CFG_GYRO_GAIN  = 2'd1,
    CFG_ANGLE_GAIN = 2'd2,
    CFG_MAG_GAIN   = 2'd3
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_MAG   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } ifp_frame_t;

  typedef struct packed {
    logic       valid;
    ifp_frame_t frame;
  } ifp_beat_t;

endpackage

@@ design/ifp_front.sv @@
module ifp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [ifp_pkg::BYTE_W-1:0]    rx_byte_i,
  output ifp_pkg::ifp_beat_t            push_o
);
  import ifp_pkg::*;

  localparam int WIN_DEPTH = FRAME_BYTES - 1;
  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(FRAME_BYTES - 1);

  logic [BYTE_W-1:0] win_q [WIN_DEPTH];
  logic [BYTE_W-1:0] win_d [WIN_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              accept;
  logic              hdr_ok;
  logic              kind_known;
  logic [BYTE_W-1:0] kind_off;

  assign accept     = in_valid_i && in_ready_i;
  assign hdr_ok     = (win_q[0] == SYNC_BYTE) && ((win_q[1] & HDR_MASK) == HDR_MASK);
  assign kind_known = (win_q[1] >= KIND_FIRST) && (win_q[1] <= KIND_LAST);
  assign kind_off   = win_q[1] - KIND_FIRST;

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    push_o.valid = 1'b0;
    push_o.frame.kind  = kind_e'(kind_off[KIND_W-1:0]);
    push_o.frame.raw_x = $signed({win_q[3], win_q[2]});
    push_o.frame.raw_y = $signed({win_q[5], win_q[4]});
    push_o.frame.raw_z = $signed({win_q[7], win_q[6]});
    if (accept) begin
      if (fill_q == LAST_FILL) begin
        if (hdr_ok) begin
          fill_d       = '0;
          push_o.valid = kind_known;
        end else begin
          for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[WIN_DEPTH-1] = rx_byte_i;
          fill_d             = LAST_FILL;
        end
      end else begin
        win_d[fill_q] = rx_byte_i;
        fill_d        = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

@@ design/ifp_queue.sv @@
module ifp_queue #(
  parameter int DEPTH = ifp_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ifp_pkg::ifp_beat_t push_i,
  input  logic               pop_i,
  output ifp_pkg::ifp_beat_t head_o,
  output logic               full_o
);
  import ifp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ifp_frame_t        mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == FULL_CNT);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.frame = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.frame;
    end
  end

endmodule

@@ design/ifp_back.sv @@
module ifp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ifp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ifp_pkg::GAIN_W-1:0]        cfg_data_i,
  input  ifp_pkg::ifp_beat_t                head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ifp_pkg::KIND_W-1:0]        kind_o,
  output logic signed [ifp_pkg::AXIS_W-1:0] axis_x_o,
  output logic signed [ifp_pkg::AXIS_W-1:0] axis_y_o,
  output logic signed [ifp_pkg::AXIS_W-1:0] axis_z_o
);
  import ifp_pkg::*;

  localparam int Q_W = PROD_W - FRAC_BITS;

  function automatic logic signed [AXIS_W-1:0] sat_axis(logic signed [PROD_W-1:0] prod);
    logic signed [Q_W-1:0] q;
    q = prod[PROD_W-1:FRAC_BITS];
    if (q[Q_W-1:AXIS_W-1] == '0 || q[Q_W-1:AXIS_W-1] == '1) begin
      return q[AXIS_W-1:0];
    end else if (q[Q_W-1]) begin
      return {1'b1, {(AXIS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(AXIS_W-1){1'b1}}};
    end
  endfunction

  logic [GAIN_W-1:0]        accel_gain_q, gyro_gain_q, angle_gain_q, mag_gain_q;
  logic [GAIN_W-1:0]        gain;
  logic                     adv_out, adv_mul;
  logic                     mul_valid_q;
  kind_e                    mul_kind_q;
  logic signed [PROD_W-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic                     out_valid_q;
  logic [KIND_W-1:0]        kind_q;
  logic signed [AXIS_W-1:0] axis_x_q, axis_y_q, axis_z_q;

  assign adv_out = !out_valid_q || out_ready_i;
  assign adv_mul = !mul_valid_q || adv_out;
  assign pop_o   = adv_mul && head_i.valid;

  always_comb begin
    case (head_i.frame.kind)
      KIND_ACCEL: gain = accel_gain_q;
      KIND_GYRO:  gain = gyro_gain_q;
      KIND_ANGLE: gain = angle_gain_q;
      KIND_MAG:   gain = mag_gain_q;
      default:    gain = mag_gain_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q <= ACCEL_GAIN_RST;
      gyro_gain_q  <= GYRO_GAIN_RST;
      angle_gain_q <= ANGLE_GAIN_RST;
      mag_gain_q   <= MAG_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ACCEL_GAIN: accel_gain_q <= cfg_data_i;
        CFG_GYRO_GAIN:  gyro_gain_q  <= cfg_data_i;
        CFG_ANGLE_GAIN: angle_gain_q <= cfg_data_i;
        CFG_MAG_GAIN:   mag_gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_mul) begin
        mul_valid_q <= head_i.valid;
      end
      if (adv_out) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mul_kind_q <= head_i.frame.kind;
      prod_x_q   <= $signed(head_i.frame.raw_x) * $signed({1'b0, gain});
      prod_y_q   <= $signed(head_i.frame.raw_y) * $signed({1'b0, gain});
      prod_z_q   <= $signed(head_i.frame.raw_z) * $signed({1'b0, gain});
    end
    if (adv_out && mul_valid_q) begin
      kind_q   <= mul_kind_q;
      axis_x_q <= sat_axis(prod_x_q);
      axis_y_q <= sat_axis(prod_y_q);
      axis_z_q <= sat_axis(prod_z_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign axis_x_o    = axis_x_q;
  assign axis_y_o    = axis_y_q;
  assign axis_z_o    = axis_z_q;

endmodule

@@ design/imu_frame_parser_top.sv @@
// One received byte is taken in every cycle while the frame queue has room.
// After the edge that takes a frame's last byte, its result passes the queue, the gain
// multiplier register and the output register in that order; output stalls can hold it.
// Throughput is one byte per cycle if the queue has room, set by the front window update.
// Reset is asynchronous and active low; it empties the window, queue and pipeline
// and loads the default gains. There is no clearing pass after reset.
module imu_frame_parser_top #(
  parameter int QUEUE_DEPTH = ifp_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ifp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ifp_pkg::GAIN_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ifp_pkg::BYTE_W-1:0]        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ifp_pkg::KIND_W-1:0]        kind_o,
  output logic signed [ifp_pkg::AXIS_W-1:0] axis_x_o,
  output logic signed [ifp_pkg::AXIS_W-1:0] axis_y_o,
  output logic signed [ifp_pkg::AXIS_W-1:0] axis_z_o
);
  import ifp_pkg::*;

  ifp_beat_t push;
  ifp_beat_t head;
  logic      pop;
  logic      queue_full;

  assign in_ready_o = !queue_full;

  ifp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .push_o     (push)
  );

  ifp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (queue_full)
  );

  ifp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .axis_x_o    (axis_x_o),
    .axis_y_o    (axis_y_o),
    .axis_z_o    (axis_z_o)
  );

endmodule

@@ design/ifp_checker.sv @@
`include "assert_macros.svh"

module ifp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [ifp_pkg::KIND_W-1:0]        kind_o,
  input logic signed [ifp_pkg::AXIS_W-1:0] axis_x_o,
  input logic signed [ifp_pkg::AXIS_W-1:0] axis_y_o,
  input logic signed [ifp_pkg::AXIS_W-1:0] axis_z_o
);

  // A stalled result beat keeps its valid and its payload.
  `IFP_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable({kind_o, axis_x_o, axis_y_o, axis_z_o}),
    "result beat changed while stalled")

  // The input side only stalls when the output side was stalled in the previous cycle.
  `IFP_ASSERT(a_in_stall_cause, clk_i, rst_ni,
    !in_ready_o |-> $past(out_valid_o && !out_ready_i),
    "input stalled without output back-pressure")

  // A fresh result is first seen valid only after the edge that takes its closing byte.
  `IFP_ASSERT(a_out_latency, clk_i, rst_ni,
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 3),
    "result appeared without a closing byte three cycles before")

  // No result is offered while reset is held.
  `IFP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind imu_frame_parser_top ifp_checker u_ifp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .axis_x_o    (axis_x_o),
  .axis_y_o    (axis_y_o),
  .axis_z_o    (axis_z_o)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ifp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int N_DIR_ROWS     = 14;

  localparam logic [BYTE_W-1:0] KB_ACCEL   = KIND_FIRST;
  localparam logic [BYTE_W-1:0] KB_GYRO    = KIND_FIRST + 8'd1;
  localparam logic [BYTE_W-1:0] KB_ANGLE   = KIND_FIRST + 8'd2;
  localparam logic [BYTE_W-1:0] KB_MAG     = KIND_LAST;
  localparam logic [BYTE_W-1:0] KB_UNKNOWN = 8'h5F;
  localparam logic [BYTE_W-1:0] JUNK       = 8'h00;

  typedef struct packed {
    kind_e                    kind;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } axes_t;

  typedef enum logic {
    ROW_FRAME,
    ROW_GAIN
  } row_op_e;

  typedef struct packed {
    row_op_e                 op;
    cfg_reg_e                reg_idx;
    logic [GAIN_W-1:0]       gain;
    logic [3:0]              lead_n;
    logic [BYTE_W-1:0]       lead_byte;
    logic [BYTE_W-1:0]       kind_byte;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic                    typed;
    axes_t                   want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR_ROWS] = '{
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd0, JUNK, KB_MAG,
      16'sd32767, 16'sh8000, 16'sd0, 1'b1, '{KIND_MAG, 20'sd32767, -20'sd32768, 20'sd0}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd3, JUNK, KB_ACCEL,
      16'sd0, 16'sd0, 16'sd0, 1'b1, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd0, JUNK, KB_GYRO,
      -16'sd1, 16'sd1, 16'sd16384, 1'b0, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd0, JUNK, KB_UNKNOWN,
      16'sd100, -16'sd100, 16'sd7, 1'b0, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd1, SYNC_BYTE, KB_ANGLE,
      16'sd4660, -16'sd4660, 16'sd1, 1'b0, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd1, JUNK, KB_ANGLE,
      16'sd4660, -16'sd4660, 16'sh8000, 1'b0, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_GAIN, CFG_ACCEL_GAIN, 21'd0, 4'd0, JUNK, JUNK,
      16'sd0, 16'sd0, 16'sd0, 1'b0, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_GAIN, CFG_GYRO_GAIN, 21'h1FFFFF, 4'd0, JUNK, JUNK,
      16'sd0, 16'sd0, 16'sd0, 1'b0, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_GAIN, CFG_ANGLE_GAIN, 21'd1048576, 4'd0, JUNK, JUNK,
      16'sd0, 16'sd0, 16'sd0, 1'b0, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_GAIN, CFG_MAG_GAIN, 21'd1, 4'd0, JUNK, JUNK,
      16'sd0, 16'sd0, 16'sd0, 1'b0, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd0, JUNK, KB_ACCEL,
      16'sd32767, 16'sh8000, -16'sd1, 1'b1, '{KIND_ACCEL, 20'sd0, 20'sd0, 20'sd0}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd0, JUNK, KB_GYRO,
      16'sd32767, 16'sh8000, 16'sd0, 1'b1, '{KIND_GYRO, 20'sd524287, 20'sh80000, 20'sd0}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd0, JUNK, KB_ANGLE,
      16'sd1, -16'sd1, 16'sd100, 1'b1, '{KIND_ANGLE, 20'sd16, -20'sd16, 20'sd1600}},
    '{ROW_FRAME, CFG_ACCEL_GAIN, 21'd0, 4'd0, JUNK, KB_MAG,
      -16'sd1, 16'sd32767, 16'sh8000, 1'b1, '{KIND_MAG, -20'sd1, 20'sd0, -20'sd1}}
  };

  logic                       clk_i;
  logic                       rst_ni      = 1'b1;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i   = '0;
  logic [GAIN_W-1:0]          cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [BYTE_W-1:0]          rx_byte_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [KIND_W-1:0]          kind_o;
  logic signed [AXIS_W-1:0]   axis_x_o;
  logic signed [AXIS_W-1:0]   axis_y_o;
  logic signed [AXIS_W-1:0]   axis_z_o;

  logic [BYTE_W-1:0] win [FRAME_BYTES];
  int                fill;
  logic [GAIN_W-1:0] gain_reg [4];

  axes_t due_results [$];
  axes_t typed_res;
  bit    typed_valid = 1'b0;
  axes_t seen_res;
  axes_t want_res;
  int    mismatches = 0;
  int    stall_cycles = 0;
  int    snd_idle_pct = 36;
  int    rcv_idle_pct = 63;

  imu_frame_parser_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .axis_x_o   (axis_x_o),
    .axis_y_o   (axis_y_o),
    .axis_z_o   (axis_z_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [AXIS_W-1:0] scale_axis(input logic signed [RAW_W-1:0] raw,
                                                          input logic [GAIN_W-1:0] gain);
    longint prod;
    longint q;
    prod = longint'(raw) * longint'(gain);
    q = prod >>> FRAC_BITS;
    if (q > 524287) q = 524287;
    if (q < -524288) q = -524288;
    return q[AXIS_W-1:0];
  endfunction

  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output axes_t res);
    logic [BYTE_W-1:0] kb;
    bit                known;
    res = '0;
    win[fill] = b;
    fill++;
    if (fill < FRAME_BYTES) return 1'b0;
    kb = win[1];
    if (win[0] != SYNC_BYTE || (kb & HDR_MASK) != HDR_MASK) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) win[i] = win[i+1];
      win[FRAME_BYTES-1] = '0;
      fill = FRAME_BYTES - 1;
      return 1'b0;
    end
    known = (kb >= KIND_FIRST) && (kb <= KIND_LAST);
    if (known) begin
      res.kind = kind_e'(kb - KIND_FIRST);
      res.x = scale_axis({win[3], win[2]}, gain_reg[res.kind]);
      res.y = scale_axis({win[5], win[4]}, gain_reg[res.kind]);
      res.z = scale_axis({win[7], win[6]}, gain_reg[res.kind]);
    end
    for (int i = 0; i < FRAME_BYTES; i++) win[i] = '0;
    fill = 0;
    return known;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    axes_t res;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (parse_byte(b, res)) begin
      if (typed_valid) due_results.push_back(typed_res);
      else due_results.push_back(res);
    end
  endtask

  task automatic send_frame(input logic [3:0] lead_n, input logic [BYTE_W-1:0] lead_byte,
                            input logic [BYTE_W-1:0] kind_byte,
                            input logic signed [RAW_W-1:0] rx, ry, rz,
                            input bit typed, input axes_t want);
    logic [BYTE_W-1:0] fb [FRAME_BYTES];
    fb[0] = SYNC_BYTE;
    fb[1] = kind_byte;
    fb[2] = rx[7:0];
    fb[3] = rx[15:8];
    fb[4] = ry[7:0];
    fb[5] = ry[15:8];
    fb[6] = rz[7:0];
    fb[7] = rz[15:8];
    for (int i = 8; i < FRAME_BYTES; i++) fb[i] = BYTE_W'($urandom_range(255));
    for (int i = 0; i < lead_n; i++) send_byte(lead_byte);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i == FRAME_BYTES - 1) begin
        typed_res   = want;
        typed_valid = typed;
      end
      send_byte(fb[i]);
    end
    typed_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(input cfg_reg_e idx, input logic [GAIN_W-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    gain_reg[idx] = val;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 24) return GAIN_W'(1048576);
    if (r < 34) return '1;
    if (r < 67) return GAIN_W'($urandom_range(70000));
    return GAIN_W'($urandom_range(1048576));
  endfunction

  function automatic logic signed [RAW_W-1:0] pick_raw();
    case ($urandom_range(15))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return RAW_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic set_random_gains();
    write_gain(CFG_ACCEL_GAIN, pick_gain());
    write_gain(CFG_GYRO_GAIN, pick_gain());
    write_gain(CFG_ANGLE_GAIN, pick_gain());
    write_gain(CFG_MAG_GAIN, pick_gain());
  endtask

  task automatic run_random(input int n_bytes);
    int                sent;
    int                pick;
    int                n;
    bit                mid_done;
    logic [BYTE_W-1:0] kb;
    sent = 0;
    mid_done = 1'b0;
    set_random_gains();
    while (sent < n_bytes) begin
      if (!mid_done && sent >= n_bytes / 2) begin
        set_random_gains();
        mid_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 72) begin
        kb = KIND_FIRST + BYTE_W'($urandom_range(3));
        send_frame(4'd0, JUNK, kb, pick_raw(), pick_raw(), pick_raw(), 1'b0, '0);
        sent += FRAME_BYTES;
      end else if (pick < 82) begin
        do kb = BYTE_W'($urandom_range(255)) | HDR_MASK;
        while (kb >= KIND_FIRST && kb <= KIND_LAST);
        send_frame(4'd0, JUNK, kb, pick_raw(), pick_raw(), pick_raw(), 1'b0, '0);
        sent += FRAME_BYTES;
      end else if (pick < 92) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          send_byte(($urandom_range(3) == 0) ? SYNC_BYTE : BYTE_W'($urandom_range(255)));
        end
        sent += n;
      end else begin
        n = $urandom_range(0, 8);
        send_byte(SYNC_BYTE);
        send_byte(KIND_FIRST + BYTE_W'($urandom_range(3)));
        for (int i = 0; i < n; i++) send_byte(BYTE_W'($urandom_range(255)));
        sent += n + 2;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_res = '{kind_e'(kind_o), axis_x_o, axis_y_o, axis_z_o};
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: kind %0d x %0d y %0d z %0d",
                   seen_res.kind, seen_res.x, seen_res.y, seen_res.z);
        end
      end else begin
        want_res = due_results.pop_front();
        if (seen_res !== want_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"mismatch: expected kind %0d x %0d y %0d z %0d, ",
                      "got kind %0d x %0d y %0d z %0d"},
                     want_res.kind, want_res.x, want_res.y, want_res.z,
                     seen_res.kind, seen_res.x, seen_res.y, seen_res.z);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    for (int i = 0; i < FRAME_BYTES; i++) win[i] = '0;
    fill = 0;
    gain_reg[CFG_ACCEL_GAIN] = ACCEL_GAIN_RST;
    gain_reg[CFG_GYRO_GAIN]  = GYRO_GAIN_RST;
    gain_reg[CFG_ANGLE_GAIN] = ANGLE_GAIN_RST;
    gain_reg[CFG_MAG_GAIN]   = MAG_GAIN_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 36;
    rcv_idle_pct = 63;
    for (int i = 0; i < N_DIR_ROWS; i++) begin
      if (DIR_ROWS[i].op == ROW_GAIN) begin
        write_gain(DIR_ROWS[i].reg_idx, DIR_ROWS[i].gain);
      end else begin
        send_frame(DIR_ROWS[i].lead_n, DIR_ROWS[i].lead_byte, DIR_ROWS[i].kind_byte,
                   DIR_ROWS[i].raw_x, DIR_ROWS[i].raw_y, DIR_ROWS[i].raw_z,
                   DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end
    run_random(530);

    snd_idle_pct = 63;
    rcv_idle_pct = 36;
    run_random(530);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(530);

    drain();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ifp_pkg.sv
design/ifp_front.sv
design/ifp_queue.sv
design/ifp_back.sv
design/imu_frame_parser_top.sv
design/ifp_checker.sv
tb/tb.sv
